// ----- hw/rtl/pip_pkg.sv -----
// pip_pkg: shared types and codes for the point-in-polygon test block.
// Used by pip_cell, pip_edge and point_in_polygon_test. No dependencies.
`timescale 1ns / 1ps

package pip_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int IDX_W   = 6;
    localparam int VCNT_W  = 7;
    localparam int CFG_W   = 7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_EDGE_INCL    = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vtx;

    typedef struct packed {
        logic vld;
        t_vtx vi;
        t_vtx vj;
    } t_edge;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_HOLD
    } t_state;

endpackage

// ----- hw/rtl/pip_cell.sv -----
// pip_cell: one vertex slot of the rotating vertex ring.
// Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_cell (
    input  logic          i_clk,
    input  logic          i_load,
    input  pip_pkg::t_vtx i_load_vtx,
    input  logic          i_shift,
    input  pip_pkg::t_vtx i_next_vtx,
    output pip_pkg::t_vtx o_vtx
);
    import pip_pkg::*;

    t_vtx r_vtx;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vtx <= i_load_vtx;
        end else if (i_shift) begin
            r_vtx <= i_next_vtx;
        end
    end

    assign o_vtx = r_vtx;

endmodule

// ----- hw/rtl/pip_edge.sv -----
// pip_edge: three-stage ray crossing test for one edge per cycle, keeps parity.
// Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_edge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    input  logic                               i_incl,
    input  logic signed [pip_pkg::COORD_W-1:0] i_tx,
    input  logic signed [pip_pkg::COORD_W-1:0] i_ty,
    input  pip_pkg::t_edge                     i_edge,
    output logic                               o_busy,
    output logic                               o_parity
);
    import pip_pkg::*;

    logic                     w_si, w_sj, w_flip;
    logic signed [DIFF_W-1:0] w_a, w_b, w_p, w_q;
    logic signed [DIFF_W-1:0] r_a, r_b, r_p, r_q;
    logic                     r_s1_vld;
    logic signed [PROD_W-1:0] w_m1, w_m2;
    logic signed [PROD_W-1:0] r_m1, r_m2;
    logic                     r_s2_vld;
    logic                     w_hit;
    logic                     r_parity;

    // Stage 1: side tests and oriented differences
    always_comb begin
        w_si   = i_incl ? (i_edge.vi.y >= i_ty) : (i_edge.vi.y > i_ty);
        w_sj   = i_incl ? (i_edge.vj.y >= i_ty) : (i_edge.vj.y > i_ty);
        w_flip = i_edge.vj.y < i_edge.vi.y;
        w_a    = DIFF_W'(i_tx) - DIFF_W'(i_edge.vi.x);
        w_b    = DIFF_W'(i_edge.vj.x) - DIFF_W'(i_edge.vi.x);
        w_q    = w_flip ? (DIFF_W'(i_edge.vi.y) - DIFF_W'(i_edge.vj.y))
                        : (DIFF_W'(i_edge.vj.y) - DIFF_W'(i_edge.vi.y));
        w_p    = w_flip ? (DIFF_W'(i_edge.vi.y) - DIFF_W'(i_ty))
                        : (DIFF_W'(i_ty) - DIFF_W'(i_edge.vi.y));
    end

    always_ff @(posedge i_clk) begin
        r_a <= w_a;
        r_b <= w_b;
        r_p <= w_p;
        r_q <= w_q;
    end

    // Stage 2: cross products, exact
    assign w_m1 = r_a * r_q;
    assign w_m2 = r_b * r_p;

    always_ff @(posedge i_clk) begin
        r_m1 <= w_m1;
        r_m2 <= w_m2;
    end

    // Stage 3: compare and toggle
    assign w_hit = i_incl ? (r_m1 <= r_m2) : (r_m1 < r_m2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_parity <= 1'b0;
        end else begin
            r_s1_vld <= i_edge.vld && (w_si ^ w_sj);
            r_s2_vld <= r_s1_vld;
            if (i_clear) begin
                r_parity <= 1'b0;
            end else if (r_s2_vld && w_hit) begin
                r_parity <= ~r_parity;
            end
        end
    end

    assign o_busy   = r_s1_vld | r_s2_vld;
    assign o_parity = r_parity;

endmodule

// ----- hw/rtl/point_in_polygon_test.sv -----
// point_in_polygon_test: crossing-number point-in-polygon test over a vertex ring.
// Depends on pip_pkg, pip_cell, pip_edge.
//
//   channel | signals                                        | direction
//   in      | i_valid/o_ready, command, index, x, y          | input transaction
//   out     | o_valid/i_ready, o_inside_res                  | result transaction
//   cfg     | i_cfg_we, i_cfg_idx, i_cfg_data                | register write
//
// A vertex write loads the indexed cell. A test rotates the first n = min(vertex_count,
// MAX_VERTICES) cells once, one edge per cycle into the crossing unit, then drains
// the crossing unit and loads the result register; o_ready stays low until then.
// Synchronous active-low reset clears control and config; the ring is not cleared.
// The result waits in an output register; new transactions are accepted meanwhile,
// but the next test holds before loading its result until that register is free.
`timescale 1ns / 1ps

module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_command,
    input  logic [pip_pkg::IDX_W-1:0]          i_vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [pip_pkg::COORD_W-1:0] i_coord_y,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_inside_res,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [pip_pkg::CFG_W-1:0]          i_cfg_data
);
    import pip_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > VCNT_W) ? CW : VCNT_W;
    localparam int KW = (CW > IDX_W) ? CW : IDX_W;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [VCNT_W-1:0]         r_vcount;
    logic                      r_incl;
    logic signed [COORD_W-1:0] r_tx, r_ty;
    logic                      r_out_valid, n_out_valid;
    logic                      r_inside, n_inside;
    logic [NW-1:0]             w_vc_ext;
    logic [CW-1:0]             w_n;
    logic                      w_in_acc, w_test_start, w_shift, w_clear;
    logic                      w_busy, w_parity;
    t_vtx                      w_load_vtx;
    t_vtx                      w_vtx  [MAX_VERTICES];
    t_vtx                      w_next [MAX_VERTICES];
    t_edge                     w_edge;

    assign w_vc_ext = NW'(r_vcount);
    assign w_n      = (w_vc_ext > NW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(w_vc_ext);

    assign o_ready      = (r_state == ST_IDLE);
    assign w_in_acc     = i_valid && o_ready;
    assign w_test_start = w_in_acc && (i_command == CMD_TEST);
    assign w_shift      = (r_state == ST_RUN);
    assign w_clear      = w_test_start;
    assign w_load_vtx   = '{x: i_coord_x, y: i_coord_y};

    // Vertex ring
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        logic w_load, w_cshift;

        assign w_load  = w_in_acc && (i_command == CMD_WRITE)
                         && (KW'(i_vertex_index) == KW'(k));
        assign w_cshift = w_shift && (CW'(k) < w_n);

        if (k == MAX_VERTICES - 1) begin : g_last
            assign w_next[k] = w_vtx[0];
        end else begin : g_mid
            assign w_next[k] = (CW'(k) == w_n - CW'(1)) ? w_vtx[0] : w_vtx[k+1];
        end

        pip_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (w_load),
            .i_load_vtx (w_load_vtx),
            .i_shift    (w_cshift),
            .i_next_vtx (w_next[k]),
            .o_vtx      (w_vtx[k])
        );
    end

    assign w_edge = '{vld: w_shift && (w_n >= CW'(2)), vi: w_vtx[0], vj: w_vtx[1]};

    pip_edge u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_clear),
        .i_incl   (r_incl),
        .i_tx     (r_tx),
        .i_ty     (r_ty),
        .i_edge   (w_edge),
        .o_busy   (w_busy),
        .o_parity (w_parity)
    );

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_incl   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VERTEX_COUNT: r_vcount <= i_cfg_data[VCNT_W-1:0];
                CFG_EDGE_INCL:    r_incl   <= i_cfg_data[0];
                default:          r_vcount <= r_vcount;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_test_start) begin
            r_tx <= i_coord_x;
            r_ty <= i_coord_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_inside    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_inside    <= n_inside;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_inside    = r_inside;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_test_start) begin
                    n_cnt   = w_n;
                    n_state = (w_n == '0) ? ST_FLUSH : ST_RUN;
                end
            end
            ST_RUN: begin
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!w_busy) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_inside    = w_parity;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_inside;

endmodule
